// File: src/selection_rect_delta_assert.svh
// assertion macros used by the result channel checker
`ifndef SELECTION_RECT_DELTA_ASSERT_SVH
`define SELECTION_RECT_DELTA_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define SRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// Types, codes and reset values shared by the selection rectangle delta block.
// ----------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

    localparam int CoordW = 16;
    localparam int MaxRects = 4;

    // request kinds
    localparam logic [1:0] REQ_CELL = 2'd0;
    localparam logic [1:0] REQ_COLS = 2'd1;
    localparam logic [1:0] REQ_ROWS = 2'd2;

    // target layers
    localparam logic [1:0] LAYER_CELL = 2'd0;
    localparam logic [1:0] LAYER_COL  = 2'd1;
    localparam logic [1:0] LAYER_ROW  = 2'd2;

    // configuration register indexes
    localparam logic CFG_LAST_COLUMN = 1'b0;
    localparam logic CFG_LAST_ROW    = 1'b1;

    localparam logic [CoordW-1:0] LAST_COLUMN_RST = 16'd255;
    localparam logic [CoordW-1:0] LAST_ROW_RST    = 16'd65535;

    typedef logic [CoordW-1:0] coord_t;

    // one request
    typedef struct packed {
        logic [1:0] req_type;
        coord_t     old_x_min;
        coord_t     old_x_max;
        coord_t     old_y_min;
        coord_t     old_y_max;
        coord_t     anchor_col;
        coord_t     anchor_row;
        coord_t     new_col;
        coord_t     new_row;
    } item_t;

    // one emitted rectangle
    typedef struct packed {
        logic       show;
        logic [1:0] layer;
        coord_t     x_min;
        coord_t     x_max;
        coord_t     y_min;
        coord_t     y_max;
    } rect_t;

    // decoded rectangle list for one request
    typedef struct packed {
        logic [2:0]               cnt;
        rect_t [MaxRects-1:0]     rects;
    } plan_t;

endpackage

`default_nettype wire

// File: src/srd_decode.sv
// ----------------------------------------------------------------------------
// srd_decode
// Combinational decision tree that turns one request into up to four
// rectangles to un-highlight and highlight.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_decode import srd_pkg::*; (
    input  wire item_t  item,
    input  wire coord_t last_column,
    input  wire coord_t last_row,
    output plan_t       plan
);

    // cell-layer rectangle
    function automatic rect_t cell_rect(input logic s, input coord_t x0, input coord_t x1,
                                        input coord_t y0, input coord_t y1);
        rect_t r;
        r.show  = s;
        r.layer = LAYER_CELL;
        r.x_min = x0;
        r.x_max = x1;
        r.y_min = y0;
        r.y_max = y1;
        return r;
    endfunction

    // one-axis span on a given layer
    function automatic rect_t span_rect(input logic s, input logic cols, input logic hdr,
                                        input coord_t lo, input coord_t hi,
                                        input coord_t lcol, input coord_t lrow);
        rect_t r;
        r.show = s;
        if (cols)
        begin
            r.layer = hdr ? LAYER_COL : LAYER_CELL;
            r.x_min = lo;
            r.x_max = hi;
            r.y_min = '0;
            r.y_max = lrow;
        end
        else
        begin
            r.layer = hdr ? LAYER_ROW : LAYER_CELL;
            r.x_min = '0;
            r.x_max = lcol;
            r.y_min = lo;
            r.y_max = hi;
        end
        return r;
    endfunction

    coord_t a, b, ya, yb, c, yc;
    coord_t ap, am, bp, bm, cp, cm, yap, yam, ybp, ybm, ycp, ycm;
    logic   anc_lo, top, c_gt, c_lt, y_gt, y_lt;
    rect_t [MaxRects-1:0] cr;
    logic [2:0] ccnt;

    // axis mode operands
    logic   cols;
    coord_t xa, xb, xanc, xc, xap, xam, xbp, xbm, xcp, xcm;
    logic   x_anc_lo, x_gt, x_lt;
    logic   s0_show, s1_show;
    coord_t s0_lo, s0_hi, s1_lo, s1_hi;
    logic   two_spans;

    // cell mode edges, all wrapping modulo 2^16
    assign a   = item.old_x_min;
    assign b   = item.old_x_max;
    assign ya  = item.old_y_min;
    assign yb  = item.old_y_max;
    assign c   = item.new_col;
    assign yc  = item.new_row;
    assign ap  = a + 16'd1;
    assign am  = a - 16'd1;
    assign bp  = b + 16'd1;
    assign bm  = b - 16'd1;
    assign cp  = c + 16'd1;
    assign cm  = c - 16'd1;
    assign yap = ya + 16'd1;
    assign yam = ya - 16'd1;
    assign ybp = yb + 16'd1;
    assign ybm = yb - 16'd1;
    assign ycp = yc + 16'd1;
    assign ycm = yc - 16'd1;

    assign anc_lo = (a == item.anchor_col);
    assign top    = (ya == item.anchor_row);
    assign c_gt   = (c > b);
    assign c_lt   = (c < a);
    assign y_gt   = (yc > yb);
    assign y_lt   = (yc < ya);

    // cell mode tree
    always_comb
    begin
        cr   = '0;
        ccnt = 3'd2;
        if (anc_lo)
        begin
            if (c_gt)
            begin
                if (top)
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b1, a, c, ybp, yc);
                        cr[1] = cell_rect(1'b1, bp, c, ya, yb);
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, yap, yb);
                        cr[1] = cell_rect(1'b1, a, c, yc, yam);
                        cr[2] = cell_rect(1'b1, bp, c, ya, ya);
                        ccnt  = 3'd3;
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ycp, yb);
                        cr[1] = cell_rect(1'b1, bp, c, ya, yc);
                    end
                end
                else
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ya, ybm);
                        cr[1] = cell_rect(1'b1, a, c, ybp, yc);
                        cr[2] = cell_rect(1'b1, bp, c, yb, yb);
                        ccnt  = 3'd3;
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b1, a, c, yc, yam);
                        cr[1] = cell_rect(1'b1, bp, c, ya, yb);
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ya, ycm);
                        cr[1] = cell_rect(1'b1, bp, c, yc, yb);
                    end
                end
            end
            else if (c_lt)
            begin
                if (top)
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b0, ap, b, ya, yb);
                        cr[1] = cell_rect(1'b1, c, am, ya, yc);
                        cr[2] = cell_rect(1'b1, a, a, ybp, yc);
                        ccnt  = 3'd3;
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, yap, yb);
                        cr[1] = cell_rect(1'b0, ap, b, ya, ya);
                        cr[2] = cell_rect(1'b1, c, a, yc, yam);
                        cr[3] = cell_rect(1'b1, c, am, ya, ya);
                        ccnt  = 3'd4;
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ycp, yb);
                        cr[1] = cell_rect(1'b0, ap, b, ya, yc);
                        cr[2] = cell_rect(1'b1, c, am, ya, yc);
                        ccnt  = 3'd3;
                    end
                end
                else
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ya, ybm);
                        cr[1] = cell_rect(1'b0, ap, b, yb, yb);
                        cr[2] = cell_rect(1'b1, c, am, yb, yc);
                        cr[3] = cell_rect(1'b1, a, a, ybp, yc);
                        ccnt  = 3'd4;
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b0, ap, b, ya, yb);
                        cr[1] = cell_rect(1'b1, c, am, yc, yb);
                        cr[2] = cell_rect(1'b1, a, a, yc, yam);
                        ccnt  = 3'd3;
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, ap, b, ya, yb);
                        cr[1] = cell_rect(1'b0, a, a, ya, ycm);
                        cr[2] = cell_rect(1'b1, c, am, yc, yb);
                        ccnt  = 3'd3;
                    end
                end
            end
            else
            begin
                if (top)
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b0, cp, b, ya, yb);
                        cr[1] = cell_rect(1'b1, a, c, ybp, yc);
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, yap, yb);
                        cr[1] = cell_rect(1'b0, cp, b, ya, ya);
                        cr[2] = cell_rect(1'b1, a, c, yc, yam);
                        ccnt  = 3'd3;
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ycp, yb);
                        cr[1] = cell_rect(1'b0, cp, b, ya, yb);
                    end
                end
                else
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ya, ybm);
                        cr[1] = cell_rect(1'b0, cp, b, yb, yb);
                        cr[2] = cell_rect(1'b1, a, c, ybp, yc);
                        ccnt  = 3'd3;
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b0, cp, b, ya, yb);
                        cr[1] = cell_rect(1'b1, a, c, yc, yam);
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ya, ycm);
                        cr[1] = cell_rect(1'b0, cp, b, yc, yb);
                    end
                end
            end
        end
        else
        begin
            if (c_gt)
            begin
                if (top)
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b0, a, bm, ya, yb);
                        cr[1] = cell_rect(1'b1, bp, c, ya, yc);
                        cr[2] = cell_rect(1'b1, b, b, ybp, yc);
                        ccnt  = 3'd3;
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, yap, yb);
                        cr[1] = cell_rect(1'b0, a, bm, ya, ya);
                        cr[2] = cell_rect(1'b1, b, c, yc, yam);
                        cr[3] = cell_rect(1'b1, bp, c, ya, ya);
                        ccnt  = 3'd4;
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, a, bm, ya, yb);
                        cr[1] = cell_rect(1'b0, b, b, ycp, yb);
                        cr[2] = cell_rect(1'b1, bp, c, ya, yc);
                        ccnt  = 3'd3;
                    end
                end
                else
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ya, ybm);
                        cr[1] = cell_rect(1'b0, a, bm, yb, yb);
                        cr[2] = cell_rect(1'b1, b, c, ybp, yc);
                        cr[3] = cell_rect(1'b1, bp, c, yb, yb);
                        ccnt  = 3'd4;
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b0, a, bm, ya, yb);
                        cr[1] = cell_rect(1'b1, bp, c, yc, yb);
                        cr[2] = cell_rect(1'b1, b, b, yc, yam);
                        ccnt  = 3'd3;
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, a, bm, ya, yb);
                        cr[1] = cell_rect(1'b0, b, b, ya, ycm);
                        cr[2] = cell_rect(1'b1, bp, c, yc, yb);
                        ccnt  = 3'd3;
                    end
                end
            end
            else if (c_lt)
            begin
                if (top)
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b1, c, b, ybp, yc);
                        cr[1] = cell_rect(1'b1, c, am, ya, yb);
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, yap, yb);
                        cr[1] = cell_rect(1'b1, c, b, yc, yam);
                        cr[2] = cell_rect(1'b1, c, am, ya, ya);
                        ccnt  = 3'd3;
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ycp, yb);
                        cr[1] = cell_rect(1'b1, c, am, ya, yc);
                    end
                end
                else
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ya, ybm);
                        cr[1] = cell_rect(1'b1, c, b, ybp, yc);
                        cr[2] = cell_rect(1'b1, c, am, yb, yb);
                        ccnt  = 3'd3;
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b1, c, b, yc, yam);
                        cr[1] = cell_rect(1'b1, c, am, ya, yb);
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ya, ycm);
                        cr[1] = cell_rect(1'b1, c, am, yc, yb);
                    end
                end
            end
            else
            begin
                if (top)
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b0, a, cm, ya, yb);
                        cr[1] = cell_rect(1'b1, c, b, ybp, yc);
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, yap, yb);
                        cr[1] = cell_rect(1'b0, a, cm, ya, ya);
                        cr[2] = cell_rect(1'b1, c, b, yc, yam);
                        ccnt  = 3'd3;
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, a, cm, ya, yb);
                        cr[1] = cell_rect(1'b0, c, b, ycp, yb);
                    end
                end
                else
                begin
                    if (y_gt)
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ya, ybm);
                        cr[1] = cell_rect(1'b0, a, cm, yb, yb);
                        cr[2] = cell_rect(1'b1, c, b, ybp, yc);
                        ccnt  = 3'd3;
                    end
                    else if (y_lt)
                    begin
                        cr[0] = cell_rect(1'b0, a, cm, ya, yb);
                        cr[1] = cell_rect(1'b1, c, b, yc, yam);
                    end
                    else
                    begin
                        cr[0] = cell_rect(1'b0, a, b, ya, ycm);
                        cr[1] = cell_rect(1'b0, a, cm, yc, yb);
                    end
                end
            end
        end
    end

    // axis mode operands: columns use x, rows use y
    assign cols = (item.req_type == REQ_COLS);
    assign xa   = cols ? item.old_x_min  : item.old_y_min;
    assign xb   = cols ? item.old_x_max  : item.old_y_max;
    assign xanc = cols ? item.anchor_col : item.anchor_row;
    assign xc   = cols ? item.new_col    : item.new_row;
    assign xap  = xa + 16'd1;
    assign xam  = xa - 16'd1;
    assign xbp  = xb + 16'd1;
    assign xbm  = xb - 16'd1;
    assign xcp  = xc + 16'd1;
    assign xcm  = xc - 16'd1;
    assign x_anc_lo = (xa == xanc);
    assign x_gt     = (xc > xb);
    assign x_lt     = (xc < xa);

    // axis mode tree: one or two spans
    always_comb
    begin
        s0_show   = 1'b0;
        s0_lo     = xa;
        s0_hi     = xcm;
        s1_show   = 1'b1;
        s1_lo     = xbp;
        s1_hi     = xc;
        two_spans = 1'b0;
        if (x_anc_lo)
        begin
            if (x_gt)
            begin
                s0_show = 1'b1;
                s0_lo   = xbp;
                s0_hi   = xc;
            end
            else if (x_lt)
            begin
                s0_lo     = xap;
                s0_hi     = xb;
                s1_lo     = xc;
                s1_hi     = xam;
                two_spans = 1'b1;
            end
            else
            begin
                s0_lo = xcp;
                s0_hi = xb;
            end
        end
        else
        begin
            if (x_gt)
            begin
                s0_lo     = xa;
                s0_hi     = xbm;
                two_spans = 1'b1;
            end
            else if (x_lt)
            begin
                s0_show = 1'b1;
                s0_lo   = xc;
                s0_hi   = xam;
            end
        end
    end

    // pick the list by request kind
    always_comb
    begin
        plan = '0;
        unique case (item.req_type)
            REQ_CELL:
            begin
                plan.cnt   = ccnt;
                plan.rects = cr;
            end
            REQ_COLS, REQ_ROWS:
            begin
                plan.cnt      = two_spans ? 3'd4 : 3'd2;
                plan.rects[0] = span_rect(s0_show, cols, 1'b0, s0_lo, s0_hi,
                                          last_column, last_row);
                plan.rects[1] = span_rect(s0_show, cols, 1'b1, s0_lo, s0_hi,
                                          last_column, last_row);
                plan.rects[2] = span_rect(s1_show, cols, 1'b0, s1_lo, s1_hi,
                                          last_column, last_row);
                plan.rects[3] = span_rect(s1_show, cols, 1'b1, s1_lo, s1_hi,
                                          last_column, last_row);
            end
            default:
            begin
                plan.cnt = 3'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/selection_rect_delta.sv
// Flow: a request is taken into the input register, decoded, and loaded into the
// result list register once that is free; its first rectangle is then offered.
// Throughput: one rectangle per cycle while out_ready is high; a request yields two to
// four rectangles, and the next request is loaded into the list as the last one leaves.
// Unknown request kinds leave the input register without producing any rectangle.
// Reset: asynchronous active low; clears valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
// selection_rect_delta
// Emits the rectangles that turn an old grid highlight into a new one, one
// rectangle per output transaction, with last marking the end of a request.
// ----------------------------------------------------------------------------
`default_nettype none

module selection_rect_delta import srd_pkg::*; (
    input  wire         clk,
    input  wire         rst_n,
    // request channel
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  req_type,
    input  wire  [15:0] old_x_min,
    input  wire  [15:0] old_x_max,
    input  wire  [15:0] old_y_min,
    input  wire  [15:0] old_y_max,
    input  wire  [15:0] anchor_col,
    input  wire  [15:0] anchor_row,
    input  wire  [15:0] new_col,
    input  wire  [15:0] new_row,
    // result channel
    output logic        out_valid,
    input  wire         out_ready,
    output logic        show,
    output logic [1:0]  layer,
    output logic [15:0] rect_x_min,
    output logic [15:0] rect_x_max,
    output logic [15:0] rect_y_min,
    output logic [15:0] rect_y_max,
    output logic        last,
    // configuration channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_data
);

    coord_t last_column_reg;
    coord_t last_row_reg;

    logic   s1_valid_reg;
    item_t  s1_item_reg;
    plan_t  plan;
    logic   s1_go;

    logic                 list_valid_reg;
    rect_t [MaxRects-1:0] list_reg;
    logic [1:0]           idx_reg;
    logic [1:0]           last_idx_reg;
    logic                 list_done;
    logic                 list_free;
    rect_t                cur;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_column_reg <= LAST_COLUMN_RST;
            last_row_reg    <= LAST_ROW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LAST_COLUMN: last_column_reg <= cfg_data;
                CFG_LAST_ROW:    last_row_reg    <= cfg_data;
                default:         last_row_reg    <= last_row_reg;
            endcase
        end
    end

    // handshake control
    assign list_done = out_ready && (idx_reg == last_idx_reg);
    assign list_free = !list_valid_reg || list_done;
    assign s1_go     = s1_valid_reg && ((plan.cnt == 3'd0) || list_free);
    assign in_ready  = !s1_valid_reg || s1_go;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.req_type   <= req_type;
            s1_item_reg.old_x_min  <= old_x_min;
            s1_item_reg.old_x_max  <= old_x_max;
            s1_item_reg.old_y_min  <= old_y_min;
            s1_item_reg.old_y_max  <= old_y_max;
            s1_item_reg.anchor_col <= anchor_col;
            s1_item_reg.anchor_row <= anchor_row;
            s1_item_reg.new_col    <= new_col;
            s1_item_reg.new_row    <= new_row;
        end
    end

    // rectangle list decode
    srd_decode u_decode (
        .item        (s1_item_reg),
        .last_column (last_column_reg),
        .last_row    (last_row_reg),
        .plan        (plan)
    );

    // result list control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else if (s1_go && (plan.cnt != 3'd0))
        begin
            list_valid_reg <= 1'b1;
            idx_reg        <= '0;
        end
        else if (list_valid_reg && out_ready)
        begin
            if (idx_reg == last_idx_reg)
            begin
                list_valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // result list payload
    always_ff @(posedge clk)
    begin
        if (s1_go && (plan.cnt != 3'd0))
        begin
            list_reg     <= plan.rects;
            last_idx_reg <= 2'(plan.cnt - 3'd1);
        end
    end

    // output ports
    assign cur        = list_reg[idx_reg];
    assign out_valid  = list_valid_reg;
    assign show       = cur.show;
    assign layer      = cur.layer;
    assign rect_x_min = cur.x_min;
    assign rect_x_max = cur.x_max;
    assign rect_y_min = cur.y_min;
    assign rect_y_max = cur.y_max;
    assign last       = (idx_reg == last_idx_reg);

endmodule

`default_nettype wire

// File: src/selection_rect_delta_chk.sv
// ----------------------------------------------------------------------------
// selection_rect_delta_chk
// Port-level checks on the result channel of the selection rectangle delta.
// ----------------------------------------------------------------------------
`default_nettype none

`include "selection_rect_delta_assert.svh"

module selection_rect_delta_chk import srd_pkg::*; (
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_ready,
    input wire [1:0]  layer,
    input wire [15:0] rect_x_min,
    input wire [15:0] rect_y_min,
    input wire        last
);

    // a stalled result stays offered
    `SRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
                     "result dropped while stalled")

    // a request's rectangles are offered back to back until last
    `SRD_ASSERT_NEXT(a_burst, out_valid && out_ready && !last, out_valid,
                     "gap inside a result burst")

    // column header rectangles span from row zero
    `SRD_ASSERT_NOW(a_col_span, out_valid && (layer == LAYER_COL), rect_y_min == 16'd0,
                    "column span not from row 0")

    // row header rectangles span from column zero
    `SRD_ASSERT_NOW(a_row_span, out_valid && (layer == LAYER_ROW), rect_x_min == 16'd0,
                    "row span not from column 0")

endmodule

bind selection_rect_delta selection_rect_delta_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .layer      (layer),
    .rect_x_min (rect_x_min),
    .rect_y_min (rect_y_min),
    .last       (last)
);

`default_nettype wire

// File: tb/selection_rect_delta_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// selection_rect_delta_checker
// Watches the request, result and register channels of the selection
// rectangle delta block. Keeps its own copy of the span registers, works out
// the rectangle list for every accepted request and compares each result
// transaction in order against it.
// ----------------------------------------------------------------------------
module selection_rect_delta_checker import srd_pkg::*; (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    input  wire         in_ready,
    input  wire  [1:0]  req_type,
    input  wire  [15:0] old_x_min,
    input  wire  [15:0] old_x_max,
    input  wire  [15:0] old_y_min,
    input  wire  [15:0] old_y_max,
    input  wire  [15:0] anchor_col,
    input  wire  [15:0] anchor_row,
    input  wire  [15:0] new_col,
    input  wire  [15:0] new_row,
    input  wire         out_valid,
    input  wire         out_ready,
    input  wire         show,
    input  wire  [1:0]  layer,
    input  wire  [15:0] rect_x_min,
    input  wire  [15:0] rect_x_max,
    input  wire  [15:0] rect_y_min,
    input  wire  [15:0] rect_y_max,
    input  wire         last,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_data,
    output int          mismatches,
    output int          pending
);

    // one rectangle the block should emit
    typedef struct packed {
        logic       show;
        logic [1:0] layer;
        coord_t     x_min;
        coord_t     x_max;
        coord_t     y_min;
        coord_t     y_max;
        logic       last;
    } expected_rect_t;

    coord_t         col_limit;
    coord_t         row_limit;
    expected_rect_t expected_rects[$];
    expected_rect_t delta_list[$];

    initial mismatches = 0;

    // one printed line per mismatch
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // append one rectangle to the list of the current request
    function automatic void add_rect(logic vis, logic [1:0] lyr, coord_t x0, coord_t x1,
                                     coord_t y0, coord_t y1);
        expected_rect_t r;
        if (delta_list.size() >= MaxRects)
            return;
        r.show  = vis;
        r.layer = lyr;
        r.x_min = x0;
        r.x_max = x1;
        r.y_min = y0;
        r.y_max = y1;
        r.last  = 1'b0;
        delta_list.push_back(r);
    endfunction

    function automatic void unmark(coord_t x0, coord_t x1, coord_t y0, coord_t y1);
        add_rect(1'b0, LAYER_CELL, x0, x1, y0, y1);
    endfunction

    function automatic void mark(coord_t x0, coord_t x1, coord_t y0, coord_t y1);
        add_rect(1'b1, LAYER_CELL, x0, x1, y0, y1);
    endfunction

    // cell mode: a, b old x span; ya, yb old y span; c, yc new corner
    function automatic void predict_cell(coord_t a, coord_t b, coord_t ya, coord_t yb,
                                         coord_t ac, coord_t ar, coord_t c, coord_t yc);
        logic anchor_top;
        anchor_top = (ya == ar);
        if (a == ac)
        begin
            // anchor on the left edge
            if (c > b)
            begin
                if (anchor_top)
                begin
                    if (yc > yb)
                    begin
                        mark(a, c, yb + 16'd1, yc); mark(b + 16'd1, c, ya, yb);
                    end
                    else if (yc < ya)
                    begin
                        unmark(a, b, ya + 16'd1, yb); mark(a, c, yc, ya - 16'd1);
                        mark(b + 16'd1, c, ya, ya);
                    end
                    else
                    begin
                        unmark(a, b, yc + 16'd1, yb); mark(b + 16'd1, c, ya, yc);
                    end
                end
                else
                begin
                    if (yc > yb)
                    begin
                        unmark(a, b, ya, yb - 16'd1); mark(a, c, yb + 16'd1, yc);
                        mark(b + 16'd1, c, yb, yb);
                    end
                    else if (yc < ya)
                    begin
                        mark(a, c, yc, ya - 16'd1); mark(b + 16'd1, c, ya, yb);
                    end
                    else
                    begin
                        unmark(a, b, ya, yc - 16'd1); mark(b + 16'd1, c, yc, yb);
                    end
                end
            end
            else if (c < a)
            begin
                if (anchor_top)
                begin
                    if (yc > yb)
                    begin
                        unmark(a + 16'd1, b, ya, yb); mark(c, a - 16'd1, ya, yc);
                        mark(a, a, yb + 16'd1, yc);
                    end
                    else if (yc < ya)
                    begin
                        unmark(a, b, ya + 16'd1, yb); unmark(a + 16'd1, b, ya, ya);
                        mark(c, a, yc, ya - 16'd1); mark(c, a - 16'd1, ya, ya);
                    end
                    else
                    begin
                        unmark(a, b, yc + 16'd1, yb); unmark(a + 16'd1, b, ya, yc);
                        mark(c, a - 16'd1, ya, yc);
                    end
                end
                else
                begin
                    if (yc > yb)
                    begin
                        unmark(a, b, ya, yb - 16'd1); unmark(a + 16'd1, b, yb, yb);
                        mark(c, a - 16'd1, yb, yc); mark(a, a, yb + 16'd1, yc);
                    end
                    else if (yc < ya)
                    begin
                        unmark(a + 16'd1, b, ya, yb); mark(c, a - 16'd1, yc, yb);
                        mark(a, a, yc, ya - 16'd1);
                    end
                    else
                    begin
                        unmark(a + 16'd1, b, ya, yb); unmark(a, a, ya, yc - 16'd1);
                        mark(c, a - 16'd1, yc, yb);
                    end
                end
            end
            else
            begin
                if (anchor_top)
                begin
                    if (yc > yb)
                    begin
                        unmark(c + 16'd1, b, ya, yb); mark(a, c, yb + 16'd1, yc);
                    end
                    else if (yc < ya)
                    begin
                        unmark(a, b, ya + 16'd1, yb); unmark(c + 16'd1, b, ya, ya);
                        mark(a, c, yc, ya - 16'd1);
                    end
                    else
                    begin
                        unmark(a, b, yc + 16'd1, yb); unmark(c + 16'd1, b, ya, yb);
                    end
                end
                else
                begin
                    if (yc > yb)
                    begin
                        unmark(a, b, ya, yb - 16'd1); unmark(c + 16'd1, b, yb, yb);
                        mark(a, c, yb + 16'd1, yc);
                    end
                    else if (yc < ya)
                    begin
                        unmark(c + 16'd1, b, ya, yb); mark(a, c, yc, ya - 16'd1);
                    end
                    else
                    begin
                        unmark(a, b, ya, yc - 16'd1); unmark(c + 16'd1, b, yc, yb);
                    end
                end
            end
        end
        else
        begin
            // anchor taken as sitting on the right edge
            if (c > b)
            begin
                if (anchor_top)
                begin
                    if (yc > yb)
                    begin
                        unmark(a, b - 16'd1, ya, yb); mark(b + 16'd1, c, ya, yc);
                        mark(b, b, yb + 16'd1, yc);
                    end
                    else if (yc < ya)
                    begin
                        unmark(a, b, ya + 16'd1, yb); unmark(a, b - 16'd1, ya, ya);
                        mark(b, c, yc, ya - 16'd1); mark(b + 16'd1, c, ya, ya);
                    end
                    else
                    begin
                        unmark(a, b - 16'd1, ya, yb); unmark(b, b, yc + 16'd1, yb);
                        mark(b + 16'd1, c, ya, yc);
                    end
                end
                else
                begin
                    if (yc > yb)
                    begin
                        unmark(a, b, ya, yb - 16'd1); unmark(a, b - 16'd1, yb, yb);
                        mark(b, c, yb + 16'd1, yc); mark(b + 16'd1, c, yb, yb);
                    end
                    else if (yc < ya)
                    begin
                        unmark(a, b - 16'd1, ya, yb); mark(b + 16'd1, c, yc, yb);
                        mark(b, b, yc, ya - 16'd1);
                    end
                    else
                    begin
                        unmark(a, b - 16'd1, ya, yb); unmark(b, b, ya, yc - 16'd1);
                        mark(b + 16'd1, c, yc, yb);
                    end
                end
            end
            else if (c < a)
            begin
                if (anchor_top)
                begin
                    if (yc > yb)
                    begin
                        mark(c, b, yb + 16'd1, yc); mark(c, a - 16'd1, ya, yb);
                    end
                    else if (yc < ya)
                    begin
                        unmark(a, b, ya + 16'd1, yb); mark(c, b, yc, ya - 16'd1);
                        mark(c, a - 16'd1, ya, ya);
                    end
                    else
                    begin
                        unmark(a, b, yc + 16'd1, yb); mark(c, a - 16'd1, ya, yc);
                    end
                end
                else
                begin
                    if (yc > yb)
                    begin
                        unmark(a, b, ya, yb - 16'd1); mark(c, b, yb + 16'd1, yc);
                        mark(c, a - 16'd1, yb, yb);
                    end
                    else if (yc < ya)
                    begin
                        mark(c, b, yc, ya - 16'd1); mark(c, a - 16'd1, ya, yb);
                    end
                    else
                    begin
                        unmark(a, b, ya, yc - 16'd1); mark(c, a - 16'd1, yc, yb);
                    end
                end
            end
            else
            begin
                if (anchor_top)
                begin
                    if (yc > yb)
                    begin
                        unmark(a, c - 16'd1, ya, yb); mark(c, b, yb + 16'd1, yc);
                    end
                    else if (yc < ya)
                    begin
                        unmark(a, b, ya + 16'd1, yb); unmark(a, c - 16'd1, ya, ya);
                        mark(c, b, yc, ya - 16'd1);
                    end
                    else
                    begin
                        unmark(a, c - 16'd1, ya, yb); unmark(c, b, yc + 16'd1, yb);
                    end
                end
                else
                begin
                    if (yc > yb)
                    begin
                        unmark(a, b, ya, yb - 16'd1); unmark(a, c - 16'd1, yb, yb);
                        mark(c, b, yb + 16'd1, yc);
                    end
                    else if (yc < ya)
                    begin
                        unmark(a, c - 16'd1, ya, yb); mark(c, b, yc, ya - 16'd1);
                    end
                    else
                    begin
                        unmark(a, b, ya, yc - 16'd1); unmark(a, c - 16'd1, yc, yb);
                    end
                end
            end
        end
    endfunction

    // full-span band on the cell layer, then on its header layer
    function automatic void add_band(logic vis, logic by_cols, coord_t lo, coord_t hi);
        if (by_cols)
        begin
            add_rect(vis, LAYER_CELL, lo, hi, 16'd0, row_limit);
            add_rect(vis, LAYER_COL, lo, hi, 16'd0, row_limit);
        end
        else
        begin
            add_rect(vis, LAYER_CELL, 16'd0, col_limit, lo, hi);
            add_rect(vis, LAYER_ROW, 16'd0, col_limit, lo, hi);
        end
    endfunction

    // column or row mode: one axis only
    function automatic void predict_axis(logic by_cols, coord_t a, coord_t b, coord_t anc,
                                         coord_t c);
        if (a == anc)
        begin
            if (c > b)
                add_band(1'b1, by_cols, b + 16'd1, c);
            else if (c < a)
            begin
                add_band(1'b0, by_cols, a + 16'd1, b);
                add_band(1'b1, by_cols, c, a - 16'd1);
            end
            else
                add_band(1'b0, by_cols, c + 16'd1, b);
        end
        else
        begin
            if (c > b)
            begin
                add_band(1'b0, by_cols, a, b - 16'd1);
                add_band(1'b1, by_cols, b + 16'd1, c);
            end
            else if (c < a)
                add_band(1'b1, by_cols, c, a - 16'd1);
            else
                add_band(1'b0, by_cols, a, c - 16'd1);
        end
    endfunction

    // expected rectangles for the request transaction on the ports
    task automatic predict_request();
        delta_list.delete();
        case (req_type)
            REQ_CELL: predict_cell(old_x_min, old_x_max, old_y_min, old_y_max,
                                   anchor_col, anchor_row, new_col, new_row);
            REQ_COLS: predict_axis(1'b1, old_x_min, old_x_max, anchor_col, new_col);
            REQ_ROWS: predict_axis(1'b0, old_y_min, old_y_max, anchor_row, new_row);
            default: ;
        endcase
        if (delta_list.size() > 0)
            delta_list[delta_list.size() - 1].last = 1'b1;
        foreach (delta_list[i])
            expected_rects.push_back(delta_list[i]);
    endtask

    // compare one result transaction against the oldest expectation
    task automatic check_result();
        expected_rect_t want;
        if (expected_rects.size() == 0)
        begin
            report_mismatch($sformatf("unexpected rectangle x %0d..%0d y %0d..%0d",
                                      rect_x_min, rect_x_max, rect_y_min, rect_y_max));
            return;
        end
        want = expected_rects.pop_front();
        compare_field("show", int'(show), int'(want.show));
        compare_field("layer", int'(layer), int'(want.layer));
        compare_field("rect_x_min", int'(rect_x_min), int'(want.x_min));
        compare_field("rect_x_max", int'(rect_x_max), int'(want.x_max));
        compare_field("rect_y_min", int'(rect_y_min), int'(want.y_min));
        compare_field("rect_y_max", int'(rect_y_max), int'(want.y_max));
        compare_field("last", int'(last), int'(want.last));
    endtask

    // sample all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_limit = LAST_COLUMN_RST;
            row_limit = LAST_ROW_RST;
            expected_rects.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LAST_COLUMN)
                    col_limit = cfg_data;
                else
                    row_limit = cfg_data;
            end
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                predict_request();
            pending = expected_rects.size();
        end
    end

endmodule

// File: tb/selection_rect_delta_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// selection_rect_delta_tb
// Drives grid selection updates into the rectangle delta block: a directed
// set over edge cases, then random drags from realistic selections mixed with
// noise, across several span register settings and idle/stall patterns.
// The checker beside the block predicts and compares every rectangle.
// ----------------------------------------------------------------------------
module selection_rect_delta_tb;
    import srd_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int StallLimit = 4000;
    localparam int SettleCycles = 8;
    localparam int RandomPerPhase = 64;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [15:0] old_x_min;
    logic [15:0] old_x_max;
    logic [15:0] old_y_min;
    logic [15:0] old_y_max;
    logic [15:0] anchor_col;
    logic [15:0] anchor_row;
    logic [15:0] new_col;
    logic [15:0] new_row;
    logic        out_valid;
    logic        out_ready;
    logic        show;
    logic [1:0]  layer;
    logic [15:0] rect_x_min;
    logic [15:0] rect_x_max;
    logic [15:0] rect_y_min;
    logic [15:0] rect_y_max;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          mismatches;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          idle_cycles = 0;

    selection_rect_delta u_top (.*);

    selection_rect_delta_checker u_checker (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side back-pressure
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic item_t make_item(logic [1:0] kind, coord_t x0, coord_t x1, coord_t y0,
                                        coord_t y1, coord_t acol, coord_t arow, coord_t ncol,
                                        coord_t nrow);
        item_t it;
        it.req_type   = kind;
        it.old_x_min  = x0;
        it.old_x_max  = x1;
        it.old_y_min  = y0;
        it.old_y_max  = y1;
        it.anchor_col = acol;
        it.anchor_row = arow;
        it.new_col    = ncol;
        it.new_row    = nrow;
        return it;
    endfunction

    function automatic coord_t clamp_coord(int v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return coord_t'(v);
    endfunction

    // selection origin, biased toward the grid borders
    function automatic coord_t pick_origin();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // mostly a real drag of a selection corner, sometimes raw noise
    function automatic item_t random_item();
        item_t      it;
        logic [1:0] kind;
        coord_t     x_lo;
        coord_t     x_hi;
        coord_t     y_lo;
        coord_t     y_hi;
        int         pick;
        if ($urandom_range(99) < 12)
            return make_item(2'($urandom_range(3)), coord_t'($urandom), coord_t'($urandom),
                             coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                             coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        pick = int'($urandom_range(99));
        kind = (pick < 60) ? REQ_CELL : ((pick < 80) ? REQ_COLS : REQ_ROWS);
        x_lo = pick_origin();
        y_lo = pick_origin();
        x_hi = clamp_coord(int'(x_lo) + int'($urandom_range(12)));
        y_hi = clamp_coord(int'(y_lo) + int'($urandom_range(12)));
        it = make_item(kind, x_lo, x_hi, y_lo, y_hi,
                       ($urandom_range(1) != 0) ? x_lo : x_hi,
                       ($urandom_range(1) != 0) ? y_lo : y_hi,
                       clamp_coord(int'(x_lo) - 16
                                   + int'($urandom_range(int'(x_hi) - int'(x_lo) + 32))),
                       clamp_coord(int'(y_lo) - 16
                                   + int'($urandom_range(int'(y_hi) - int'(y_lo) + 32))));
        return it;
    endfunction

    // one request transaction, entered and left at a falling edge
    task automatic drive_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        req_type   = it.req_type;
        old_x_min  = it.old_x_min;
        old_x_max  = it.old_x_max;
        old_y_min  = it.old_y_min;
        old_y_max  = it.old_y_max;
        anchor_col = it.anchor_col;
        anchor_row = it.anchor_row;
        new_col    = it.new_col;
        new_row    = it.new_row;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold requests until every expected rectangle is out
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input coord_t value);
        wait_drained();
        // unknown kinds leave no result behind, so let the block settle before the write
        repeat (SettleCycles) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stimulus
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_CELL;
        old_x_min  = '0;
        old_x_max  = '0;
        old_y_min  = '0;
        old_y_max  = '0;
        anchor_col = '0;
        anchor_row = '0;
        new_col    = '0;
        new_row    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_LAST_COLUMN;
        cfg_data   = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: cell drags in every direction, border wraps, both axis modes
        drive_item(make_item(REQ_CELL, 10, 20, 10, 20, 10, 10, 30, 30));
        drive_item(make_item(REQ_CELL, 10, 20, 10, 20, 20, 20, 5, 5));
        drive_item(make_item(REQ_CELL, 10, 20, 10, 20, 10, 20, 5, 15));
        drive_item(make_item(REQ_CELL, 10, 20, 10, 20, 20, 10, 15, 3));
        drive_item(make_item(REQ_CELL, 10, 20, 10, 20, 15, 15, 25, 5));
        drive_item(make_item(REQ_CELL, 0, 0, 0, 0, 0, 0, 0, 0));
        drive_item(make_item(REQ_CELL, 0, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0));
        drive_item(make_item(REQ_CELL, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF));
        drive_item(make_item(REQ_CELL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        drive_item(make_item(REQ_COLS, 10, 20, 16'h5A5A, 16'hA5A5, 10, 16'h1234, 30, 16'hFFFF));
        drive_item(make_item(REQ_COLS, 10, 20, 0, 0, 20, 0, 5, 0));
        drive_item(make_item(REQ_COLS, 10, 20, 0, 0, 10, 0, 5, 0));
        drive_item(make_item(REQ_COLS, 10, 20, 0, 0, 20, 0, 15, 0));
        drive_item(make_item(REQ_COLS, 0, 16'hFFFF, 0, 0, 16'hFFFF, 0, 0, 0));
        drive_item(make_item(REQ_ROWS, 16'hA5A5, 16'h5A5A, 10, 20, 16'hFFFF, 10, 16'h4321, 30));
        drive_item(make_item(REQ_ROWS, 0, 0, 10, 20, 0, 20, 0, 5));
        drive_item(make_item(REQ_ROWS, 0, 0, 10, 20, 0, 10, 0, 15));
        drive_item(make_item(REQ_ROWS, 0, 0, 0, 16'hFFFF, 0, 0, 0, 16'hFFFF));
        drive_item(make_item(REQ_UNKNOWN, 16'hFFFF, 0, 16'hFFFF, 0, 1, 2, 3, 4));
        drive_item(make_item(REQ_CELL, 16'hFFFF, 0, 16'hFFFF, 0, 16'h8000, 16'h7FFF, 1, 2));

        // random phases: idle pattern and span registers change between them
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_LAST_COLUMN, 16'hFFFF);
                    write_reg(CFG_LAST_ROW, 16'd0);
                end
                1:
                begin
                    write_reg(CFG_LAST_COLUMN, 16'd0);
                    write_reg(CFG_LAST_ROW, 16'hFFFF);
                end
                2:
                begin
                    write_reg(CFG_LAST_COLUMN, coord_t'($urandom));
                    write_reg(CFG_LAST_ROW, coord_t'($urandom));
                end
                default:
                begin
                    write_reg(CFG_LAST_COLUMN, LAST_COLUMN_RST);
                    write_reg(CFG_LAST_ROW, 16'd1023);
                end
            endcase
            send_idle_pct  = (phase == 1) ? 47 : ((phase == 3) ? 15 : 0);
            recv_stall_pct = (phase == 2) ? 47 : ((phase == 3) ? 15 : 0);
            for (int n = 0; n < RandomPerPhase; n++)
            begin
                if ($urandom_range(39) == 0)
                    wait_drained();
                drive_item(random_item());
            end
        end

        // drain and verdict
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
